/* src/nbc_pkg.sv */
// Package for the naive Bayes classifier: sizes, codes, state type.
// No dependencies; nbc_mul, naive_bayes_classify and the bench import it.
package nbc_pkg;

    localparam int MAX_CLASSES  = 16;
    localparam int MAX_FEATURES = 64;
    localparam int FRAC_BITS    = 16;

    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int FEAT_W  = $clog2(MAX_FEATURES);
    localparam int WORD_W  = 32;
    localparam int SCORE_W = 48;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 66;

    // request operations
    localparam logic [1:0] OP_PRIOR  = 2'd0;
    localparam logic [1:0] OP_PARAM  = 2'd1;
    localparam logic [1:0] OP_SCALE  = 2'd2;
    localparam logic [1:0] OP_DETECT = 2'd3;

    // likelihood models
    localparam logic [1:0] KIND_GAUSS = 2'd0;
    localparam logic [1:0] KIND_MULTI = 2'd1;
    localparam logic [1:0] KIND_BERN  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_SCALE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SC_RD,
        S_SC_MUL,
        S_SC_SAT,
        S_C_RD,
        S_C_MUL1,
        S_C_MUL2,
        S_C_ACC
    } t_state;

    typedef enum logic {
        R_EMPTY,
        R_FULL
    } t_res_state;

endpackage

/* src/nbc_req_if.sv */
// Request channel of the classifier: valid/ready plus the request fields.
// Depends on nothing.
interface nbc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [3:0]         class_index;
    logic [5:0]         feature_index;
    logic signed [31:0] word_first;
    logic signed [31:0] word_second;
    logic signed [31:0] word_third;
    logic               last_feature;

    modport source (output valid, operation, class_index, feature_index, word_first,
                    word_second, word_third, last_feature, input ready);
    modport sink   (input valid, operation, class_index, feature_index, word_first,
                    word_second, word_third, last_feature, output ready);
endinterface

/* src/nbc_res_if.sv */
// Result channel of the classifier: valid/ready plus class and score.
// Depends on nothing.
interface nbc_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         predicted_class;
    logic signed [47:0] best_score;

    modport source (output valid, predicted_class, best_score, input ready);
    modport sink   (input valid, predicted_class, best_score, output ready);
endinterface

/* src/nbc_mul.sv */
// Shared signed multiplier with registered product.
// Depends on nbc_pkg.
module nbc_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [nbc_pkg::OPND_W-1:0]    i_a,
    input  logic signed [nbc_pkg::OPND_W-1:0]    i_b,
    output logic signed [nbc_pkg::PROD_W-1:0]    o_prod
);
    import nbc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // product holds while i_en is low
    always_ff @(posedge i_clk) begin
        if (i_en)
            r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

/* src/naive_bayes_classify.sv */
// Naive Bayes classifier top level: request decode, memories, sequencer.
// Depends on nbc_pkg, nbc_req_if, nbc_res_if and nbc_mul.
//
// Write requests (prior, class-feature words, scaling) leave the sequencer idle.
// A feature request walks the active classes with one shared 33x33
// multiplier: accept, then read, multiply and saturate when scaling is on,
// then per class a parameter memory read, two multiplier passes for
// gaussian or one for multinomial or bernoulli, and the score update. The
// request port is busy for the whole walk; the result register lets the
// next request in while a result still waits, unless a second result is
// due before the first is taken.
module naive_bayes_classify (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    nbc_req_if.sink     i_req,
    nbc_res_if.source   o_res
);
    import nbc_pkg::*;

    // configuration
    logic [1:0] r_kind;
    logic [4:0] r_count;
    logic       r_scale_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_GAUSS;
            r_count    <= 5'd1;
            r_scale_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND:  r_kind     <= i_cfg_data[1:0];
                CFG_COUNT: r_count    <= i_cfg_data;
                CFG_SCALE: r_scale_en <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // active class count minus one
    logic [CLS_W-1:0] last_cls;
    always_comb begin
        if (r_count == 5'd0)
            last_cls = '0;
        else if (r_count > 5'(MAX_CLASSES))
            last_cls = CLS_W'(MAX_CLASSES - 1);
        else
            last_cls = CLS_W'(r_count - 5'd1);
    end

    t_state r_state, n_state;
    t_res_state r_res, n_res;

    logic accept;
    assign accept = i_req.valid && i_req.ready;

    logic [CLS_W-1:0]  r_cls;
    logic [FEAT_W-1:0] r_feat;
    logic signed [WORD_W-1:0] r_x;
    logic r_last;
    logic r_open;

    // memories
    logic [3*WORD_W-1:0] m_param [MAX_CLASSES*MAX_FEATURES];
    logic [2*WORD_W-1:0] m_scale [MAX_FEATURES];
    logic [3*WORD_W-1:0] r_pdata;
    logic [2*WORD_W-1:0] r_sdata;
    logic signed [WORD_W-1:0] r_prior [MAX_CLASSES];
    logic signed [SCORE_W-1:0] r_score [MAX_CLASSES];

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_PARAM)
            m_param[{i_req.class_index, i_req.feature_index}] <=
                {i_req.word_third, i_req.word_second, i_req.word_first};
        r_pdata <= m_param[{r_cls, r_feat}];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_SCALE)
            m_scale[i_req.feature_index] <= {i_req.word_second, i_req.word_first};
        r_sdata <= m_scale[r_feat];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.operation == OP_PRIOR)
            r_prior[i_req.class_index] <= i_req.word_first;
    end

    logic signed [WORD_W-1:0] p_first, p_second, p_third, s_off, s_gain;
    assign p_first  = r_pdata[WORD_W-1:0];
    assign p_second = r_pdata[2*WORD_W-1:WORD_W];
    assign p_third  = r_pdata[3*WORD_W-1:2*WORD_W];
    assign s_off    = r_sdata[WORD_W-1:0];
    assign s_gain   = r_sdata[2*WORD_W-1:WORD_W];

    // shared multiplier operands
    logic signed [OPND_W-1:0] d, ad, aiv, mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [WORD_W-1:0] sq;
    logic mul_en;

    assign d   = OPND_W'(r_x) - OPND_W'(p_first);
    assign ad  = d[OPND_W-1] ? -d : d;
    assign aiv = p_second[WORD_W-1] ? -OPND_W'(p_second) : OPND_W'(p_second);
    assign sq  = (|prod[PROD_W-1:WORD_W+FRAC_BITS]) ? '1 : prod[WORD_W+FRAC_BITS-1:FRAC_BITS];

    // product is held while the score update waits on the result register
    assign mul_en = (r_state != S_C_ACC);

    always_comb begin
        mul_a = OPND_W'(r_x);
        mul_b = OPND_W'(p_first);
        case (r_state)
            S_SC_MUL: begin
                mul_a = OPND_W'(r_x) - OPND_W'(s_off);
                mul_b = OPND_W'(s_gain);
            end
            S_C_MUL1: begin
                if (r_kind == KIND_GAUSS) begin
                    mul_a = ad;
                    mul_b = ad;
                end
            end
            S_C_MUL2: begin
                mul_a = {1'b0, sq};
                mul_b = aiv;
            end
            default: ;
        endcase
    end

    nbc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // scaled feature, floor shift then saturate
    logic signed [PROD_W-FRAC_BITS-1:0] sc_shift;
    logic signed [WORD_W-1:0] sc_x;
    assign sc_shift = prod[PROD_W-1:FRAC_BITS];
    always_comb begin
        if (sc_shift > (PROD_W-FRAC_BITS)'(signed'(32'sh7FFFFFFF)))
            sc_x = 32'sh7FFFFFFF;
        else if (sc_shift < (PROD_W-FRAC_BITS)'(signed'(-33'sh080000000)))
            sc_x = 32'sh80000000;
        else
            sc_x = sc_shift[WORD_W-1:0];
    end

    // likelihood term and saturating score update
    localparam int SUM_W = SCORE_W + 2;
    logic signed [SUM_W-1:0] term, gq, base, sum;
    logic signed [SCORE_W-1:0] new_score;

    assign gq = SUM_W'(prod[PROD_W-4:FRAC_BITS+1]);

    always_comb begin
        case (r_kind)
            KIND_GAUSS: term = (p_second[WORD_W-1] ? gq : -gq) - SUM_W'(p_third);
            KIND_MULTI: term = (r_x > 0) ? SUM_W'(prod[PROD_W-1:FRAC_BITS]) : '0;
            KIND_BERN:  term = (r_x > WORD_W'(1 << (FRAC_BITS - 1))) ?
                               SUM_W'(p_first) : SUM_W'(p_second);
            default:    term = '0;
        endcase
        base = SUM_W'(r_score[r_cls]);
        sum  = base + term;
        if (sum > SUM_W'(48'sh7FFFFFFFFFFF))
            new_score = 48'sh7FFFFFFFFFFF;
        else if (sum < -SUM_W'(49'sh0800000000000))
            new_score = 48'sh800000000000;
        else
            new_score = sum[SCORE_W-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req.operation == OP_DETECT)
                    n_state = r_scale_en ? S_SC_RD : S_C_RD;
            end
            S_SC_RD:  n_state = S_SC_MUL;
            S_SC_MUL: n_state = S_SC_SAT;
            S_SC_SAT: n_state = S_C_RD;
            S_C_RD:   n_state = S_C_MUL1;
            S_C_MUL1: n_state = (r_kind == KIND_GAUSS) ? S_C_MUL2 : S_C_ACC;
            S_C_MUL2: n_state = S_C_ACC;
            S_C_ACC: begin
                if (r_cls != last_cls)
                    n_state = S_C_RD;
                else if (!r_last || r_res == R_EMPTY || o_res.ready)
                    n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    logic done_last;
    assign done_last = (r_state == S_C_ACC) && (r_cls == last_cls) && r_last &&
                       (r_res == R_EMPTY || o_res.ready);

    // result register state
    always_comb begin
        n_res = r_res;
        unique case (r_res)
            R_EMPTY: if (done_last) n_res = R_FULL;
            R_FULL:  if (o_res.ready && !done_last) n_res = R_EMPTY;
            default: n_res = R_EMPTY;
        endcase
    end

    // outputs
    logic [CLS_W-1:0] r_best_cls;
    logic signed [SCORE_W-1:0] r_best;
    logic [CLS_W-1:0] r_out_cls;
    logic signed [SCORE_W-1:0] r_out_score;

    always_comb begin
        i_req.ready           = (r_state == S_IDLE);
        o_res.valid           = (r_res == R_FULL);
        o_res.predicted_class = 4'(r_out_cls);
        o_res.best_score      = r_out_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= R_EMPTY;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (r_state == S_C_ACC && n_state == S_IDLE)
                r_open <= !r_last;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_feat <= i_req.feature_index;
                    r_x    <= i_req.word_first;
                    r_last <= i_req.last_feature;
                    r_cls  <= '0;
                    // sample start: every class score takes its prior
                    if (i_req.operation == OP_DETECT && !r_open) begin
                        for (int c = 0; c < MAX_CLASSES; c++)
                            r_score[c] <= SCORE_W'(r_prior[c]);
                    end
                end
            end
            S_SC_SAT: r_x <= sc_x;
            S_C_ACC: begin
                if (n_state != S_C_ACC) begin
                    r_score[r_cls] <= new_score;
                    if (r_cls == '0 || new_score > r_best) begin
                        r_best     <= new_score;
                        r_best_cls <= r_cls;
                    end
                    if (r_cls != last_cls)
                        r_cls <= r_cls + 1'b1;
                end
            end
            default: ;
        endcase
        if (done_last) begin
            if (r_cls == '0 || new_score > r_best) begin
                r_out_cls   <= r_cls;
                r_out_score <= new_score;
            end else begin
                r_out_cls   <= r_best_cls;
                r_out_score <= r_best;
            end
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_state == S_IDLE)
        else $error("request taken while busy");
    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_C_ACC |-> r_cls <= last_cls)
        else $error("class walk beyond active count");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.best_score))
        else $error("pending result lost");
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state) == S_C_ACC)
        else $error("result without class walk");
endmodule

/* bench/tb.sv */
// Self-checking bench for naive_bayes_classify: random model loads and samples,
// scored by an in-bench predictor. Depends on nbc_pkg, nbc_req_if, nbc_res_if and the DUT.
module tb;
    import nbc_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         cls;
        logic [5:0]         feat;
        logic signed [31:0] w1;
        logic signed [31:0] w2;
        logic signed [31:0] w3;
        logic               last;
    } req_t;

    typedef struct packed {
        logic [3:0]         cls;
        logic signed [47:0] score;
    } verdict_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [4:0] i_cfg_data;

    nbc_req_if req_ch ();
    nbc_res_if res_ch ();

    naive_bayes_classify dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    // predictor state
    logic signed [31:0] prior_mem [MAX_CLASSES];
    logic signed [31:0] mean_mem  [MAX_CLASSES*MAX_FEATURES];
    logic signed [31:0] ivar_mem  [MAX_CLASSES*MAX_FEATURES];
    logic signed [31:0] lden_mem  [MAX_CLASSES*MAX_FEATURES];
    logic signed [31:0] offs_mem  [MAX_FEATURES];
    logic signed [31:0] gain_mem  [MAX_FEATURES];
    logic signed [47:0] score_acc [MAX_CLASSES];
    logic               in_sample = 1'b0;
    logic [1:0]         kind_reg;
    logic [4:0]         count_reg;
    logic               scale_reg;

    req_t     pending_reqs [$];
    verdict_t want_verdicts [$];
    int       mismatches = 0;
    int       hold_gap;
    int       res_stall;
    bit       hold_for_drain = 1'b0;

    localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -64'sh8000_0000_0000;

    function automatic longint sat48(longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // gaussian log-likelihood term for one class/feature
    function automatic longint gauss_term(longint x, int idx);
        longint d, iv, q;
        logic [63:0] ad, sq, aiv;
        d = x - longint'(mean_mem[idx]);
        iv = longint'(ivar_mem[idx]);
        ad = (d < 0) ? -d : d;
        sq = (ad * ad) >> FRAC_BITS;
        if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
        aiv = (iv < 0) ? -iv : iv;
        q = longint'((sq * aiv) >> (FRAC_BITS + 1));
        return ((iv < 0) ? q : -q) - longint'(lden_mem[idx]);
    endfunction

    // apply one accepted request to the predictor
    task automatic score_request(input req_t r);
        longint x, term;
        int n, idx, best;
        verdict_t v;
        case (r.op)
            OP_PRIOR: prior_mem[r.cls] = r.w1;
            OP_PARAM: begin
                idx = r.cls * MAX_FEATURES + r.feat;
                mean_mem[idx] = r.w1;
                ivar_mem[idx] = r.w2;
                lden_mem[idx] = r.w3;
            end
            OP_SCALE: begin
                offs_mem[r.feat] = r.w1;
                gain_mem[r.feat] = r.w2;
            end
            default: begin
                n = (count_reg == 0) ? 1 : (count_reg > MAX_CLASSES) ? MAX_CLASSES : count_reg;
                if (!in_sample) begin
                    for (int c = 0; c < MAX_CLASSES; c++)
                        score_acc[c] = 48'(longint'(prior_mem[c]));
                    in_sample = 1'b1;
                end
                x = longint'(r.w1);
                if (scale_reg)
                    x = sat32(((x - longint'(offs_mem[r.feat])) *
                               longint'(gain_mem[r.feat])) >>> FRAC_BITS);
                for (int c = 0; c < n; c++) begin
                    idx = c * MAX_FEATURES + r.feat;
                    term = 0;
                    if (kind_reg == KIND_GAUSS)
                        term = gauss_term(x, idx);
                    else if (kind_reg == KIND_MULTI) begin
                        if (x > 0) term = (x * longint'(mean_mem[idx])) >>> FRAC_BITS;
                    end else if (kind_reg == KIND_BERN)
                        term = (x > (64'sd1 <<< (FRAC_BITS - 1))) ?
                               longint'(mean_mem[idx]) : longint'(ivar_mem[idx]);
                    score_acc[c] = 48'(sat48(longint'(score_acc[c]) + term));
                end
                if (r.last) begin
                    best = 0;
                    for (int c = 1; c < n; c++)
                        if (score_acc[c] > score_acc[best]) best = c;
                    in_sample = 1'b0;
                    v.cls = best[3:0];
                    v.score = score_acc[best];
                    want_verdicts.insert(want_verdicts.size(), v);
                end
            end
        endcase
    endtask

    // queue one request behind those already pending
    task automatic enqueue_req(input req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_req(logic [1:0] op, int cls, int feat, logic [31:0] w1,
                                      logic [31:0] w2, logic [31:0] w3, bit last);
        req_t r;
        r.op = op; r.cls = cls[3:0]; r.feat = feat[5:0];
        r.w1 = w1; r.w2 = w2; r.w3 = w3; r.last = last;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= OP_PRIOR;
            req_ch.class_index <= '0;
            req_ch.feature_index <= '0;
            req_ch.word_first <= '0;
            req_ch.word_second <= '0;
            req_ch.word_third <= '0;
            req_ch.last_feature <= 1'b0;
            hold_gap <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) score_request(req_t'({req_ch.operation,
                req_ch.class_index, req_ch.feature_index, req_ch.word_first,
                req_ch.word_second, req_ch.word_third, req_ch.last_feature}));
            if (!req_ch.valid || req_ch.ready) begin
                if (hold_gap > 0) begin
                    hold_gap <= hold_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_for_drain) begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.operation <= r.op;
                    req_ch.class_index <= r.cls;
                    req_ch.feature_index <= r.feat;
                    req_ch.word_first <= r.w1;
                    req_ch.word_second <= r.w2;
                    req_ch.word_third <= r.w3;
                    req_ch.last_feature <= r.last;
                    hold_gap <= pick_gap();
                end else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (want_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result class %0d score %0d",
                        res_ch.predicted_class, res_ch.best_score);
                end else begin
                    verdict_t v;
                    v = want_verdicts.pop_front();
                    if (v.cls !== res_ch.predicted_class || v.score !== res_ch.best_score) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp class %0d score %0d, got %0d %0d",
                                v.cls, v.score, res_ch.predicted_class, res_ch.best_score);
                    end
                end
            end
            if (res_stall > 0) begin
                res_stall <= res_stall - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) res_stall <= pick_gap();
            end
        end
    end

    // wait until the block is idle and no verdict is outstanding
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid) @(posedge i_clk);
        while (want_verdicts.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KIND) kind_reg = val[1:0];
        else if (idx == CFG_COUNT) count_reg = val;
        else scale_reg = val[0];
        @(posedge i_clk);
    endtask

    // model load: every prior, and the parameter and scale entries of the first nfeat features
    task automatic load_tables(int nfeat);
        for (int c = 0; c < MAX_CLASSES; c++) begin
            enqueue_req(make_req(OP_PRIOR, c, 0, rand_word(), $urandom, $urandom,
                                 1'($urandom_range(0, 1))));
            for (int f = 0; f < nfeat; f++)
                enqueue_req(make_req(OP_PARAM, c, f, rand_word(), rand_word(),
                                     rand_word(), 1'($urandom_range(0, 1))));
        end
        for (int f = 0; f < nfeat; f++)
            enqueue_req(make_req(OP_SCALE, 0, f, rand_word(), rand_word(),
                                 $urandom, 1'($urandom_range(0, 1))));
    endtask

    // one sample of features, with an occasional mid-sample rewrite
    task automatic push_sample(int nfeat);
        int len;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                enqueue_req(make_req(2'($urandom_range(0, 2)), $urandom_range(0, 15),
                    $urandom_range(0, nfeat - 1), rand_word(), rand_word(), rand_word(), 1));
            enqueue_req(make_req(OP_DETECT, $urandom, $urandom_range(0, nfeat - 1),
                rand_word(), $urandom, $urandom, k == len - 1));
        end
    endtask

    // stimulus
    initial begin
        int nfeat;
        logic [4:0] kinds [4];
        kinds = '{5'd0, 5'd1, 5'd2, 5'd3};
        kind_reg = 0; count_reg = 1; scale_reg = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_KIND; i_cfg_data = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: whole feature space loaded once, extremes on one sample each kind
        load_tables(MAX_FEATURES);
        drain();
        for (int k = 0; k < 4; k++) begin
            write_cfg(CFG_KIND, kinds[k]);
            write_cfg(CFG_COUNT, k == 0 ? 5'd16 : k == 1 ? 5'd0 : k == 2 ? 5'd31 : 5'd1);
            write_cfg(CFG_SCALE, 5'(k[0]));
            enqueue_req(make_req(OP_DETECT, 0, 63, 32'h7FFF_FFFF, 0, 0, 0));
            enqueue_req(make_req(OP_DETECT, 15, 0, 32'h8000_0000, 0, 0, 0));
            enqueue_req(make_req(OP_DETECT, 3, 5, 32'h0000_8001, 0, 0, 0));
            enqueue_req(make_req(OP_DETECT, 3, 6, 32'h0000_8000, 0, 0, 1));
            drain();
        end

        // random phases with varying configuration
        for (int ph = 0; ph < 10; ph++) begin
            write_cfg(CFG_KIND, $urandom_range(0, 3) == 0 ? 5'd3 : 5'($urandom_range(0, 2)));
            write_cfg(CFG_COUNT, $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
                                                            : 5'($urandom_range(1, 16)));
            write_cfg(CFG_SCALE, 5'($urandom_range(0, 1)));
            nfeat = ($urandom_range(0, 3) == 0) ? MAX_FEATURES : 4;
            if (ph % 6 == 5) load_tables(nfeat);
            for (int s = 0; s < 16; s++) push_sample(nfeat);
            if (ph == 3) begin
                while (pending_reqs.size() > 40) @(posedge i_clk);
                hold_for_drain = 1;
                while (req_ch.valid || want_verdicts.size() > 0) @(posedge i_clk);
                hold_for_drain = 0;
            end
            drain();
        end

        if (mismatches == 0 && want_verdicts.size() == 0)
            $display("naive_bayes_classify test passed");
        else
            $display("naive_bayes_classify test failed");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("naive_bayes_classify test failed");
        $finish;
    end
endmodule
